>>> hw/rtl/vlpf_pkg.sv
// Shared types and constants for the varint length-prefixed framer.
package vlpf_pkg;

    // Buffer size limit; offsets saturate at the smaller of its last offset and 65535.
    localparam logic [32:0] MAX_BUFFER_BYTES = 33'd65536;
    localparam logic [32:0] OFF_LIMIT        = MAX_BUFFER_BYTES - 33'd1;
    localparam logic [15:0] OFF_CAP          =
        (OFF_LIMIT > 33'h0_FFFF) ? 16'hFFFF : OFF_LIMIT[15:0];

    // Region counter saturation value.
    localparam logic [15:0] REGION_CAP = 16'hFFFF;

    // Varint layout: seven value bits per byte, bit seven flags a continuation.
    localparam int          GROUP_BITS = 7;
    localparam int          LEN_BITS   = 32;
    localparam int          CONT_BIT   = 7;
    localparam logic [4:0]  SHIFT_STEP = 5'd7;
    // A continuation seen at or beyond this shift would pass bit 31.
    localparam logic [4:0]  SHIFT_LAST = 5'(LEN_BITS - GROUP_BITS);

    // Depth of the queue between parser and output stage.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Parser phase.
    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_PAY  = 2'd1,
        PH_STOP = 2'd2
    } phase_t;

    // One result item.
    typedef struct packed {
        logic        region_valid;
        logic [15:0] region_index;
        logic [15:0] region_start;
        logic [15:0] region_end;
        logic        buffer_done;
    } result_item_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> hw/rtl/varint_length_prefixed_framer_core.sv
// Top level of the varint length-prefixed framer: parser, queue and output stage.
//
//  Channel  Direction  tdata                         tuser         tlast
//  s_axis   in         [7:0] data_byte               -             last_byte
//  m_axis   out        [15:0] region_index,          region_valid  buffer_done
//                      [31:16] region_start,
//                      [47:32] region_end
//
// One byte is accepted per clock unless the result queue is full.
// A result is queued when its byte is accepted and leaves via the output register.
// Reset (aresetn low, synchronous) empties the queue and returns the parser to
// reading a length prefix at offset zero.
// A stalled m_axis fills a four-entry result queue; s_axis_tready drops only
// while that queue is full.
module varint_length_prefixed_framer_core
    import vlpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] region_index, [31:16] region_start,
                                        // [47:32] region_end
    output logic        m_axis_tuser,   // region_valid
    output logic        m_axis_tlast    // buffer_done
);

    q_status_t    q_stat;
    logic         q_push;
    logic         q_pop;
    result_item_t q_push_data;
    result_item_t q_pop_data;
    result_item_t out_data;

    // Byte parser.
    vlpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Result queue.
    vlpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .q_stat    (q_stat)
    );

    // Output register.
    vlpf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_stat    (q_stat),
        .pop_data  (q_pop_data),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    // Pack the result fields onto the master side.
    assign m_axis_tdata = {out_data.region_end, out_data.region_start,
                           out_data.region_index};
    assign m_axis_tuser = out_data.region_valid;
    assign m_axis_tlast = out_data.buffer_done;

`ifndef SYNTHESIS
    // The parser never writes a result into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_push |-> !q_stat.full)
        else $error("result pushed into full queue");

    // The output stage never reads an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_stat.empty)
        else $error("result popped from empty queue");

    // A result without a region is only ever the end-of-buffer marker, all fields zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == 48'd0)))
        else $error("empty region that is not a clean end marker");
`endif

endmodule

>>> hw/rtl/vlpf_front.sv
// Front part: accepts bytes, parses varint lengths and payloads, and queues results.
module vlpf_front
    import vlpf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  q_status_t    q_stat,
    output logic         push,
    output result_item_t push_data
);

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [4:0]  shift_reg, shift_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] start_reg, start_next;
    logic [30:0] rem_reg, rem_next;
    logic [15:0] regions_reg, regions_next;

    logic         accept;
    logic         emit;
    logic         has_res;
    result_item_t res;
    logic [31:0]  group_val;
    logic [31:0]  acc_or;
    logic [30:0]  rem_dec;

    // A request is taken whenever the queue has room for its possible result.
    assign in_ready  = !q_stat.full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && has_res;
    assign push_data = res;

    assign group_val = {25'd0, data_byte[GROUP_BITS-1:0]} << shift_reg;
    assign acc_or    = acc_reg | group_val;
    assign rem_dec   = rem_reg - 31'd1;

    // Parse one byte and form the result it causes.
    always_comb begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        shift_next   = shift_reg;
        off_next     = off_reg;
        start_next   = start_reg;
        rem_next     = rem_reg;
        regions_next = regions_reg;
        emit         = 1'b0;
        has_res      = 1'b0;
        res          = '0;

        case (phase_reg)
            PH_LEN: begin
                if (shift_reg == 5'd0) begin
                    start_next = off_reg;
                end
                if (data_byte[CONT_BIT]) begin
                    acc_next = acc_or;
                    if (shift_reg >= SHIFT_LAST) begin
                        phase_next = PH_STOP;
                    end else begin
                        shift_next = shift_reg + SHIFT_STEP;
                    end
                end else begin
                    shift_next = 5'd0;
                    acc_next   = '0;
                    if (acc_or[LEN_BITS-1]) begin
                        phase_next = PH_STOP;
                    end else if (acc_or == 32'd0) begin
                        emit = 1'b1;
                    end else begin
                        rem_next   = acc_or[30:0];
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                rem_next = rem_dec;
                if (rem_dec == 31'd0) begin
                    emit       = 1'b1;
                    phase_next = PH_LEN;
                end
            end
            default: begin
                // Stopped: bytes are only counted.
            end
        endcase

        if (emit && (regions_reg != REGION_CAP)) begin
            regions_next = regions_reg + 16'd1;
        end

        if (!last_byte) begin
            if (off_reg < OFF_CAP) begin
                off_next = off_reg + 16'd1;
            end
            has_res = emit;
            res     = '{region_valid: 1'b1, region_index: regions_reg,
                        region_start: start_next, region_end: off_reg,
                        buffer_done: 1'b0};
        end else begin
            // The last byte always closes the buffer with one result.
            has_res = 1'b1;
            if (emit) begin
                res = '{region_valid: 1'b1, region_index: regions_reg,
                        region_start: start_next, region_end: off_reg,
                        buffer_done: 1'b1};
            end else if (phase_next == PH_PAY) begin
                res = '{region_valid: 1'b1, region_index: regions_next,
                        region_start: start_next, region_end: off_reg,
                        buffer_done: 1'b1};
            end else if (regions_next == 16'd0) begin
                res = '{region_valid: 1'b1, region_index: 16'd0,
                        region_start: 16'd0, region_end: off_reg,
                        buffer_done: 1'b1};
            end else begin
                res = '{region_valid: 1'b0, region_index: 16'd0,
                        region_start: 16'd0, region_end: 16'd0,
                        buffer_done: 1'b1};
            end
            phase_next   = PH_LEN;
            acc_next     = '0;
            shift_next   = 5'd0;
            off_next     = 16'd0;
            start_next   = 16'd0;
            rem_next     = '0;
            regions_next = 16'd0;
        end
    end

    // Parser state advances once per accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEN;
            acc_reg     <= '0;
            shift_reg   <= 5'd0;
            off_reg     <= 16'd0;
            start_reg   <= 16'd0;
            rem_reg     <= '0;
            regions_reg <= 16'd0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            shift_reg   <= shift_next;
            off_reg     <= off_next;
            start_reg   <= start_next;
            rem_reg     <= rem_next;
            regions_reg <= regions_next;
        end
    end

endmodule

>>> hw/rtl/vlpf_queue.sv
// Short result queue between the parser and the output stage.
module vlpf_queue
    import vlpf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  result_item_t push_data,
    input  logic         pop,
    output result_item_t pop_data,
    output q_status_t    q_stat
);

    result_item_t      mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/vlpf_back.sv
// Back part: output register that drains the queue toward the result channel.
module vlpf_back
    import vlpf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  q_status_t    q_stat,
    input  result_item_t pop_data,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output result_item_t out_data
);

    logic         valid_reg, valid_next;
    result_item_t data_reg;

    // Load a new result when the register is empty or being taken.
    assign pop       = !q_stat.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= pop_data;
        end
    end

endmodule

>>> tb/region_checker.sv
// Checker for the varint framer: predicts packet regions per byte and compares them on m_axis.
module region_checker
    import vlpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [15:0] region_index, [31:16] region_start,
                                        // [47:32] region_end
    input  logic        m_axis_tuser,   // region_valid
    input  logic        m_axis_tlast,   // buffer_done
    output int          fail_count,
    output int          pending
);

    // Parser state, kept apart from the block under test.
    phase_t      phase;
    logic [31:0] len_acc;
    logic [4:0]  shift;
    logic [15:0] next_off;
    logic [15:0] pkt_start;
    logic [30:0] pay_left;
    logic [15:0] regions_seen;

    // Regions expected on the result channel, oldest first.
    result_item_t regions_due[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic result_item_t make_region(input logic valid,
                                                 input logic [15:0] idx,
                                                 input logic [15:0] first,
                                                 input logic [15:0] final_off,
                                                 input logic done);
        result_item_t r;
        r.region_valid = valid;
        r.region_index = idx;
        r.region_start = first;
        r.region_end   = final_off;
        r.buffer_done  = done;
        return r;
    endfunction

    // Every buffer starts from a clean parser.
    task automatic clear_parser();
        phase        = PH_LEN;
        len_acc      = '0;
        shift        = '0;
        next_off     = '0;
        pkt_start    = '0;
        pay_left     = '0;
        regions_seen = '0;
    endtask

    // Advance the parser by one byte and queue the region it closes, if any.
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        logic [15:0] here;
        logic [15:0] idx;
        logic        found;
        here  = next_off;
        idx   = regions_seen;
        found = 1'b0;
        case (phase)
            PH_LEN: begin
                if (shift == 5'd0)
                    pkt_start = here;
                // Groups that land above bit 31 are simply lost.
                len_acc = len_acc | (32'(b[6:0]) << shift);
                if (b[7]) begin
                    // A fifth continuation byte would need a shift of 35.
                    if (shift >= 5'd25)
                        phase = PH_STOP;
                    else
                        shift = shift + 5'd7;
                end else begin
                    shift = '0;
                    if (len_acc[31])
                        phase = PH_STOP;
                    else if (len_acc == 32'd0)
                        found = 1'b1;
                    else begin
                        pay_left = len_acc[30:0];
                        phase    = PH_PAY;
                    end
                    len_acc = '0;
                end
            end
            PH_PAY: begin
                pay_left = pay_left - 31'd1;
                if (pay_left == 31'd0) begin
                    found = 1'b1;
                    phase = PH_LEN;
                end
            end
            default: ;
        endcase

        if (found && regions_seen < REGION_CAP)
            regions_seen = regions_seen + 16'd1;

        if (!fin) begin
            if (next_off < OFF_CAP)
                next_off = next_off + 16'd1;
            if (found)
                regions_due.push_back(make_region(1'b1, idx, pkt_start, here, 1'b0));
        end else begin
            // The last byte always closes the buffer with exactly one result.
            if (found)
                regions_due.push_back(make_region(1'b1, idx, pkt_start, here, 1'b1));
            else if (phase == PH_PAY)
                regions_due.push_back(make_region(1'b1, regions_seen, pkt_start, here, 1'b1));
            else if (regions_seen == 16'd0)
                regions_due.push_back(make_region(1'b1, 16'd0, 16'd0, here, 1'b1));
            else
                regions_due.push_back(make_region(1'b0, 16'd0, 16'd0, 16'd0, 1'b1));
            clear_parser();
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Watch both channels; values seen here are the ones the block sampled at this edge.
    always @(posedge aclk) begin
        result_item_t want;
        if (!aresetn) begin
            clear_parser();
            regions_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (regions_due.size() == 0) begin
                    $error("result request arrived with no region expected");
                    fail_count++;
                end else begin
                    want = regions_due.pop_front();
                    compare_field("region_valid", 32'(want.region_valid),
                                  32'(m_axis_tuser));
                    compare_field("region_index", 32'(want.region_index),
                                  32'(m_axis_tdata[15:0]));
                    compare_field("region_start", 32'(want.region_start),
                                  32'(m_axis_tdata[31:16]));
                    compare_field("region_end", 32'(want.region_end),
                                  32'(m_axis_tdata[47:32]));
                    compare_field("buffer_done", 32'(want.buffer_done),
                                  32'(m_axis_tlast));
                end
            end
        end
        pending <= regions_due.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the framer testbench: clock, reset, byte stimulus, result back-pressure and verdict.
module testbench;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_BYTES  = 667;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int bytes_sent = 0;
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    // Bytes of the buffer being built; the final one goes out with tlast.
    logic [7:0] frame_q[$];

    varint_length_prefixed_framer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    region_checker region_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_asks != hold_served) begin
            hold_served   <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Offer one byte, with random gaps in front of it, and wait for its request to complete.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= fin;
        do
            @(posedge aclk);
        while (!s_axis_tready);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        bytes_sent += frame_q.size();
        frame_q.delete();
    endtask

    // Length prefix, optionally stretched with zero-valued continuation groups.
    task automatic put_varint(input logic [31:0] value, input int pad);
        int          groups;
        logic [31:0] rest;
        groups = 1;
        while (groups < 5 && (value >> (7 * groups)) != 0)
            groups++;
        groups = (groups + pad > 5) ? 5 : groups + pad;
        rest = value;
        for (int i = 0; i < groups; i++) begin
            frame_q.push_back({i != groups - 1, rest[6:0]});
            rest = rest >> 7;
        end
    endtask

    task automatic add_payload(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    // One random buffer: mostly well-formed packets, some broken prefixes, some noise.
    task automatic random_frame();
        int kind;
        int cut;
        int len;
        int pad;
        kind = $urandom_range(99);
        if (kind < 12) begin
            add_payload($urandom_range(1, 12));
        end else begin
            repeat ($urandom_range(0, 5)) begin
                cut = $urandom_range(99);
                len = (cut < 15) ? 0 : (cut < 85) ? $urandom_range(1, 12)
                                                  : $urandom_range(13, 300);
                pad = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
                put_varint(len, pad);
                add_payload(len);
            end
            cut = $urandom_range(99);
            if (kind >= 80) begin
                // Broken prefix: overlong varint, negative length, or a huge length.
                if (cut < 40)
                    repeat (5) frame_q.push_back({1'b1, 7'($urandom)});
                else if (cut < 80)
                    put_varint(32'h8000_0000 | 32'($urandom), 0);
                else
                    put_varint({1'b0, 31'($urandom)} | 32'h0001_0000, 0);
                add_payload($urandom_range(0, 4));
            end else if (cut < 20) begin
                // Buffer ends inside a payload.
                len = $urandom_range(2, 30);
                put_varint(len, 0);
                add_payload($urandom_range(0, len - 1));
            end else if (cut < 35) begin
                // Buffer ends inside a length prefix.
                repeat ($urandom_range(1, 4)) frame_q.push_back({1'b1, 7'($urandom)});
            end
        end
        if (frame_q.size() == 0)
            frame_q.push_back(8'($urandom));
        send_frame();
    endtask

    initial begin
        int start_count;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 14;
        recv_idle = 52;

        // Directed buffers.
        // Single zero-length packet.
        frame_q = '{8'h00};
        send_frame();
        // One-byte packet, then a zero-length packet on the last byte.
        frame_q = '{8'h01, 8'h5A, 8'h00};
        send_frame();
        // Largest one-byte length ending on the last byte: cut off in the payload.
        frame_q = '{8'h7F};
        send_frame();
        // Largest positive length, cut off after two payload bytes.
        frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h07, 8'hAA, 8'hBB};
        send_frame();
        // Negative length and no region: whole buffer becomes one region.
        frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
        send_frame();
        // A region, then an overlong varint: end marker only.
        frame_q = '{8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h22};
        send_frame();
        // A region, then the buffer ends inside a varint.
        frame_q = '{8'h00, 8'h81};
        send_frame();

        // Random phases with different idling on each side.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle = 14; recv_idle = 52; end
                1: begin send_idle = 52; recv_idle = 14; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            // Hold the result side while zero-length packets pile up behind it.
            hold_asks <= hold_asks + 1;
            repeat (24) frame_q.push_back(8'h00);
            send_frame();
            start_count = bytes_sent;
            while (bytes_sent - start_count < PHASE_BYTES)
                random_frame();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
